@@ hw/rtl/jem_pkg.sv @@
package jem_pkg;

    localparam int ITER_LIMIT_DEF = 1024;
    localparam int FRAC_BITS_DEF  = 28;
    localparam int REG_FRAC       = 28;
    localparam int QUEUE_DEPTH    = 2;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 32;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_C_REAL       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_C_IMAG       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_STEP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_REAL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_IMAG  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER     = 3'd7;

    localparam logic [30:0] PIXEL_STEP_RST   = 31'd279620;
    localparam logic [12:0] FRAME_WIDTH_RST  = 13'd4000;
    localparam logic [12:0] FRAME_HEIGHT_RST = 13'd2256;
    localparam logic [10:0] MAX_ITER_RST     = 11'd1024;

    typedef struct packed {
        logic [11:0] column;
        logic [11:0] row;
    } in_item_t;

    typedef struct packed {
        logic        escaped;
        logic [23:0] pixel_index;
    } out_item_t;

    typedef struct packed {
        logic signed [31:0] c_real;
        logic signed [31:0] c_imag;
        logic [30:0]        pixel_step;
        logic signed [31:0] center_real;
        logic signed [31:0] center_imag;
        logic [12:0]        frame_width;
        logic [12:0]        frame_height;
        logic [10:0]        max_iterations;
    } cfg_t;

endpackage

@@ hw/rtl/julia_escape_mask_core.sv @@
// Each item gets at most min(max_iterations, ITER_LIMIT) updates of z and stops early
// once it escapes; a far start point or a zero iteration count skips the loop. The
// iterator takes a new item only after the last one has moved to the output register;
// each round of the loop passes through the states ST_MUL, ST_SUM and ST_STEP.
// Up to three items wait ahead of the iterator (input stage and two-entry queue).
// Reset: asynchronous, active low; clears all handshake state and loads register defaults.
module julia_escape_mask_core #(
    parameter int ITER_LIMIT = jem_pkg::ITER_LIMIT_DEF,
    parameter int FRAC_BITS  = jem_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [jem_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [jem_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  jem_pkg::in_item_t                 in_item,
    output logic                              out_valid,
    input  logic                              out_ready,
    output jem_pkg::out_item_t                out_item
);
    import jem_pkg::*;

    localparam int DESC_W = 2 * (FRAC_BITS + 7) + 25;

    cfg_t              cfg_reg;
    logic              f_valid;
    logic              f_ready;
    logic [DESC_W-1:0] f_desc;
    logic              q_valid;
    logic              q_ready;
    logic [DESC_W-1:0] q_desc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.c_real         <= '0;
            cfg_reg.c_imag         <= '0;
            cfg_reg.pixel_step     <= PIXEL_STEP_RST;
            cfg_reg.center_real    <= '0;
            cfg_reg.center_imag    <= '0;
            cfg_reg.frame_width    <= FRAME_WIDTH_RST;
            cfg_reg.frame_height   <= FRAME_HEIGHT_RST;
            cfg_reg.max_iterations <= MAX_ITER_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_C_REAL:       cfg_reg.c_real         <= cfg_data;
                REG_C_IMAG:       cfg_reg.c_imag         <= cfg_data;
                REG_PIXEL_STEP:   cfg_reg.pixel_step     <= cfg_data[30:0];
                REG_CENTER_REAL:  cfg_reg.center_real    <= cfg_data;
                REG_CENTER_IMAG:  cfg_reg.center_imag    <= cfg_data;
                REG_FRAME_WIDTH:  cfg_reg.frame_width    <= cfg_data[12:0];
                REG_FRAME_HEIGHT: cfg_reg.frame_height   <= cfg_data[12:0];
                REG_MAX_ITER:     cfg_reg.max_iterations <= cfg_data[10:0];
                default:          ;
            endcase
        end
    end

    jem_front #(
        .FRAC_BITS(FRAC_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .desc_valid (f_valid),
        .desc_ready (f_ready),
        .desc       (f_desc)
    );

    jem_queue #(
        .DEPTH(QUEUE_DEPTH),
        .WIDTH(DESC_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_desc),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_desc)
    );

    jem_back #(
        .ITER_LIMIT(ITER_LIMIT),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .desc_valid (q_valid),
        .desc_ready (q_ready),
        .desc       (q_desc),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_item   (out_item)
    );

endmodule

@@ hw/rtl/jem_front.sv @@
module jem_front #(
    parameter int FRAC_BITS = jem_pkg::FRAC_BITS_DEF,
    localparam int DESC_W = 2 * (FRAC_BITS + 7) + 25
) (
    input  logic                clk,
    input  logic                rst_n,
    input  jem_pkg::cfg_t       cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  jem_pkg::in_item_t   in_item,
    output logic                desc_valid,
    input  logic                desc_ready,
    output logic [DESC_W-1:0]   desc
);
    import jem_pkg::*;

    localparam int ZW   = FRAC_BITS + 7;
    localparam int SHL  = (FRAC_BITS >= REG_FRAC) ? FRAC_BITS - REG_FRAC : 0;
    localparam int SHR  = (FRAC_BITS >= REG_FRAC) ? 0 : REG_FRAC - FRAC_BITS;
    localparam int PW   = 44;
    localparam int SUMW = 45;
    localparam int SW   = SUMW + SHL;
    localparam logic signed [SW-1:0] FOUR_S =
        {{(SW - FRAC_BITS - 3){1'b0}}, 3'b100, {FRAC_BITS{1'b0}}};

    typedef struct packed {
        logic                 far;
        logic signed [ZW-1:0] zr;
        logic signed [ZW-1:0] zi;
        logic [23:0]          pixel_index;
    } desc_t;

    logic signed [13:0]     dx;
    logic signed [13:0]     dy;
    logic signed [45:0]     prod_r_full;
    logic signed [45:0]     prod_i_full;
    logic [24:0]            idx_full;

    logic                   s1_valid_reg;
    logic signed [PW-1:0]   prod_r_reg;
    logic signed [PW-1:0]   prod_i_reg;
    logic [23:0]            idx_reg;

    logic signed [SUMW-1:0] sum_r;
    logic signed [SUMW-1:0] sum_i;
    logic signed [SW-1:0]   sh_r;
    logic signed [SW-1:0]   sh_i;
    desc_t                  desc_d;

    // First stage: offsets from the frame center, scaled by the pixel size.
    always_comb
    begin
        dx = $signed({2'b00, in_item.column}) - $signed({2'b00, cfg.frame_width[12:1]});
        dy = $signed({2'b00, in_item.row}) - $signed({2'b00, cfg.frame_height[12:1]});
        prod_r_full = $signed({1'b0, cfg.pixel_step}) * dx;
        prod_i_full = $signed({1'b0, cfg.pixel_step}) * dy;
        idx_full = in_item.row * cfg.frame_width + 25'(in_item.column);
    end

    assign in_ready = !s1_valid_reg || desc_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            prod_r_reg <= prod_r_full[PW-1:0];
            prod_i_reg <= prod_i_full[PW-1:0];
            idx_reg    <= idx_full[23:0];
        end
    end

    // Second stage: add the center, move to the internal fraction width and
    // flag start points that lie on or outside the radius-4 square.
    always_comb
    begin
        sum_r = SUMW'(prod_r_reg) + SUMW'(cfg.center_real);
        sum_i = SUMW'(prod_i_reg) + SUMW'(cfg.center_imag);
        sh_r  = (SW'(sum_r) <<< SHL) >>> SHR;
        sh_i  = (SW'(sum_i) <<< SHL) >>> SHR;
        desc_d.far = (sh_r >= FOUR_S) || (sh_r <= -FOUR_S)
                  || (sh_i >= FOUR_S) || (sh_i <= -FOUR_S);
        desc_d.zr = sh_r[ZW-1:0];
        desc_d.zi = sh_i[ZW-1:0];
        desc_d.pixel_index = idx_reg;
    end

    assign desc_valid = s1_valid_reg;
    assign desc = desc_d;

endmodule

@@ hw/rtl/jem_queue.sv @@
module jem_queue #(
    parameter int DEPTH = jem_pkg::QUEUE_DEPTH,
    parameter int WIDTH = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);
    import jem_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue fill count beyond depth");

endmodule

@@ hw/rtl/jem_back.sv @@
module jem_back #(
    parameter int ITER_LIMIT = jem_pkg::ITER_LIMIT_DEF,
    parameter int FRAC_BITS  = jem_pkg::FRAC_BITS_DEF,
    localparam int DESC_W = 2 * (FRAC_BITS + 7) + 25
) (
    input  logic                clk,
    input  logic                rst_n,
    input  jem_pkg::cfg_t       cfg,
    input  logic                desc_valid,
    output logic                desc_ready,
    input  logic [DESC_W-1:0]   desc,
    output logic                out_valid,
    input  logic                out_ready,
    output jem_pkg::out_item_t  out_item
);
    import jem_pkg::*;

    localparam int ZW    = FRAC_BITS + 7;
    localparam int MW    = FRAC_BITS + 6;
    localparam int H     = (MW + 1) / 2;
    localparam int PPW   = 2 * H;
    localparam int PFW   = 2 * MW;
    localparam int QW    = FRAC_BITS + 12;
    localparam int UW    = QW + 2;
    localparam int CW    = FRAC_BITS + 4;
    localparam int SHL   = (FRAC_BITS >= REG_FRAC) ? FRAC_BITS - REG_FRAC : 0;
    localparam int SHR   = (FRAC_BITS >= REG_FRAC) ? 0 : REG_FRAC - FRAC_BITS;
    localparam int CEXT  = 32 + SHL;
    localparam int CNT_W = $clog2(ITER_LIMIT + 1);
    localparam logic [QW:0] FOUR_Q =
        {{(QW + 1 - FRAC_BITS - 3){1'b0}}, 3'b100, {FRAC_BITS{1'b0}}};

    typedef struct packed {
        logic                 far;
        logic signed [ZW-1:0] zr;
        logic signed [ZW-1:0] zi;
        logic [23:0]          pixel_index;
    } desc_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_STEP,
        ST_DONE
    } state_t;

    state_t               state_reg;
    logic [CNT_W-1:0]     k_reg;
    logic signed [ZW-1:0] zr_reg;
    logic signed [ZW-1:0] zi_reg;
    logic                 esc_reg;
    logic [23:0]          idx_reg;
    logic                 out_valid_reg;
    out_item_t            out_item_reg;

    logic [PPW-1:0]       pll_reg [3];
    logic [PPW-1:0]       plh_reg [3];
    logic [PPW-1:0]       phl_reg [3];
    logic [PPW-1:0]       phh_reg [3];
    logic                 xneg_reg;
    logic [QW-1:0]        q_reg [3];

    desc_t                d;
    logic [CNT_W-1:0]     n_lim;
    logic signed [CEXT-1:0] cr_sh;
    logic signed [CEXT-1:0] ci_sh;
    logic signed [CW-1:0] cr;
    logic signed [CW-1:0] ci;
    logic signed [ZW-1:0] neg_r;
    logic signed [ZW-1:0] neg_i;
    logic [MW-1:0]        mag_r;
    logic [MW-1:0]        mag_i;
    logic [MW-1:0]        opa [3];
    logic [MW-1:0]        opb [3];
    logic [PPW-1:0]       ll_d [3];
    logic [PPW-1:0]       lh_d [3];
    logic [PPW-1:0]       hl_d [3];
    logic [PPW-1:0]       hh_d [3];
    logic [PFW-1:0]       full_d [3];
    logic [QW-1:0]        q_d [3];
    logic [QW:0]          mag_sum;
    logic                 escape_now;
    logic signed [UW-1:0] xs;
    logic signed [UW-1:0] nr;
    logic signed [UW-1:0] ni;
    logic                 out_free;

    assign d = desc;

    always_comb
    begin
        if (32'(cfg.max_iterations) > 32'(ITER_LIMIT))
        begin
            n_lim = CNT_W'(ITER_LIMIT);
        end
        else
        begin
            n_lim = CNT_W'(cfg.max_iterations);
        end
        cr_sh = (CEXT'(cfg.c_real) <<< SHL) >>> SHR;
        ci_sh = (CEXT'(cfg.c_imag) <<< SHL) >>> SHR;
        cr = cr_sh[CW-1:0];
        ci = ci_sh[CW-1:0];
    end

    // Products are formed on magnitudes, each split into four partial
    // products; squares of the new z double as the next round's squares.
    always_comb
    begin
        neg_r = -zr_reg;
        neg_i = -zi_reg;
        mag_r = zr_reg[ZW-1] ? neg_r[MW-1:0] : zr_reg[MW-1:0];
        mag_i = zi_reg[ZW-1] ? neg_i[MW-1:0] : zi_reg[MW-1:0];
        opa[0] = mag_r;
        opb[0] = mag_r;
        opa[1] = mag_i;
        opb[1] = mag_i;
        opa[2] = mag_r;
        opb[2] = mag_i;
        for (int p = 0; p < 3; p++)
        begin
            ll_d[p] = PPW'(opa[p][H-1:0]) * PPW'(opb[p][H-1:0]);
            lh_d[p] = PPW'(opa[p][H-1:0]) * PPW'(opb[p][MW-1:H]);
            hl_d[p] = PPW'(opa[p][MW-1:H]) * PPW'(opb[p][H-1:0]);
            hh_d[p] = PPW'(opa[p][MW-1:H]) * PPW'(opb[p][MW-1:H]);
            full_d[p] = PFW'(pll_reg[p]) + (PFW'(plh_reg[p]) << H)
                      + (PFW'(phl_reg[p]) << H) + (PFW'(phh_reg[p]) << (2 * H));
            q_d[p] = full_d[p][PFW-1:FRAC_BITS];
        end
    end

    always_comb
    begin
        mag_sum = (QW + 1)'(q_reg[0]) + (QW + 1)'(q_reg[1]);
        // The bound test applies to an updated z only, never to the start point.
        escape_now = (k_reg != '0) && (mag_sum > FOUR_Q);
        xs = xneg_reg ? -$signed({2'b00, q_reg[2]}) : $signed({2'b00, q_reg[2]});
        nr = $signed({2'b00, q_reg[0]}) - $signed({2'b00, q_reg[1]}) + UW'(cr);
        ni = (xs <<< 1) + UW'(ci);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MUL)
        begin
            pll_reg  <= ll_d;
            plh_reg  <= lh_d;
            phl_reg  <= hl_d;
            phh_reg  <= hh_d;
            xneg_reg <= zr_reg[ZW-1] ^ zi_reg[ZW-1];
        end
        if (state_reg == ST_SUM)
        begin
            q_reg <= q_d;
        end
    end

    assign out_free   = !out_valid_reg || out_ready;
    assign desc_ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            zr_reg        <= '0;
            zi_reg        <= '0;
            esc_reg       <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_item_reg  <= '0;
        end
        else
        begin
            // In the finishing state the output register is reloaded below instead.
            if (out_valid_reg && out_ready && state_reg != ST_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (desc_valid)
                    begin
                        zr_reg  <= d.zr;
                        zi_reg  <= d.zi;
                        idx_reg <= d.pixel_index;
                        k_reg   <= '0;
                        if (n_lim == '0)
                        begin
                            esc_reg   <= 1'b0;
                            state_reg <= ST_DONE;
                        end
                        else if (d.far)
                        begin
                            esc_reg   <= 1'b1;
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            state_reg <= ST_MUL;
                        end
                    end
                end
                ST_MUL:
                begin
                    state_reg <= ST_SUM;
                end
                ST_SUM:
                begin
                    state_reg <= ST_STEP;
                end
                ST_STEP:
                begin
                    if (escape_now)
                    begin
                        esc_reg   <= 1'b1;
                        state_reg <= ST_DONE;
                    end
                    else if (k_reg == n_lim)
                    begin
                        esc_reg   <= 1'b0;
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        zr_reg    <= nr[ZW-1:0];
                        zi_reg    <= ni[ZW-1:0];
                        k_reg     <= k_reg + CNT_W'(1);
                        state_reg <= ST_MUL;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg            <= 1'b1;
                        out_item_reg.escaped     <= esc_reg;
                        out_item_reg.pixel_index <= idx_reg;
                        state_reg                <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    a_pop_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
        (desc_valid && desc_ready) |=> (state_reg != ST_IDLE))
        else $error("descriptor taken but iterator stayed idle");

    a_done_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_free) |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("finished item not moved to the output register");

    a_no_start_escape: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP && k_reg == '0) |=> !(state_reg == ST_DONE && esc_reg))
        else $error("escape flagged before the first update");

endmodule

@@ tb/sv/jem_pixel_checker.sv @@
module jem_pixel_checker #(
    parameter int ITER_LIMIT = jem_pkg::ITER_LIMIT_DEF,
    parameter int FRAC_BITS  = jem_pkg::FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [jem_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [jem_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  jem_pkg::in_item_t              in_item,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  jem_pkg::out_item_t             out_item,
    output int                             mismatches,
    output int                             outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import jem_pkg::*;

    cfg_t      regs;
    out_item_t expected_masks[$];
    out_item_t want;

    // Register values are Q.28; the iterator may use another fraction width.
    function automatic longint to_fixed(longint q28);
        if (FRAC_BITS >= REG_FRAC)
            return q28 * (longint'(1) << (FRAC_BITS - REG_FRAC));
        return q28 >>> (REG_FRAC - FRAC_BITS);
    endfunction

    // Exact product, truncated toward zero to the fraction width.
    function automatic longint fix_mul(longint a, longint b);
        logic [127:0] mag_a;
        logic [127:0] mag_b;
        logic [127:0] prod;
        logic [62:0]  q;
        mag_a = (a < 0) ? 128'(-a) : 128'(a);
        mag_b = (b < 0) ? 128'(-b) : 128'(b);
        prod  = mag_a * mag_b;
        q     = prod[FRAC_BITS +: 63];
        return ((a < 0) != (b < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function automatic out_item_t escape_of_pixel(in_item_t px, cfg_t c);
        longint      col, row, w, h, step, four, cr, ci, zr, zi, nr, ni;
        int          rounds;
        logic        esc;
        logic [63:0] lin;
        out_item_t   res;
        col    = longint'(px.column);
        row    = longint'(px.row);
        w      = longint'(c.frame_width);
        h      = longint'(c.frame_height);
        step   = longint'(c.pixel_step);
        four   = longint'(4) << FRAC_BITS;
        cr     = to_fixed(longint'($signed(c.c_real)));
        ci     = to_fixed(longint'($signed(c.c_imag)));
        zr     = to_fixed(step * (col - w / 2) + longint'($signed(c.center_real)));
        zi     = to_fixed(step * (row - h / 2) + longint'($signed(c.center_imag)));
        rounds = (c.max_iterations > ITER_LIMIT) ? ITER_LIMIT : c.max_iterations;
        esc    = 1'b0;
        for (int k = 0; k < rounds; k++)
        begin
            // A start point this far out cannot come back inside the radius.
            if (zr >= four || zr <= -four || zi >= four || zi <= -four)
            begin
                esc = 1'b1;
                break;
            end
            nr = fix_mul(zr, zr) - fix_mul(zi, zi) + cr;
            ni = 2 * fix_mul(zr, zi) + ci;
            zr = nr;
            zi = ni;
            if (fix_mul(zr, zr) + fix_mul(zi, zi) > four)
            begin
                esc = 1'b1;
                break;
            end
        end
        lin             = row * w + col;
        res.escaped     = esc;
        res.pixel_index = lin[23:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs.c_real         <= '0;
            regs.c_imag         <= '0;
            regs.pixel_step     <= PIXEL_STEP_RST;
            regs.center_real    <= '0;
            regs.center_imag    <= '0;
            regs.frame_width    <= FRAME_WIDTH_RST;
            regs.frame_height   <= FRAME_HEIGHT_RST;
            regs.max_iterations <= MAX_ITER_RST;
            expected_masks.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_masks.size() == 0)
                begin
                    $error("pixel_index: expected no item, actual %0d", out_item.pixel_index);
                    mismatches++;
                end
                else
                begin
                    want = expected_masks.pop_front();
                    if (out_item.escaped !== want.escaped)
                    begin
                        $error("escaped: expected %0d, actual %0d",
                               want.escaped, out_item.escaped);
                        mismatches++;
                    end
                    if (out_item.pixel_index !== want.pixel_index)
                    begin
                        $error("pixel_index: expected %0d, actual %0d",
                               want.pixel_index, out_item.pixel_index);
                        mismatches++;
                    end
                end
            end
            if (in_valid && in_ready)
                expected_masks.push_back(escape_of_pixel(in_item, regs));
            outstanding <= expected_masks.size();
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_C_REAL:       regs.c_real         <= cfg_data;
                    REG_C_IMAG:       regs.c_imag         <= cfg_data;
                    REG_PIXEL_STEP:   regs.pixel_step     <= cfg_data[30:0];
                    REG_CENTER_REAL:  regs.center_real    <= cfg_data;
                    REG_CENTER_IMAG:  regs.center_imag    <= cfg_data;
                    REG_FRAME_WIDTH:  regs.frame_width    <= cfg_data[12:0];
                    REG_FRAME_HEIGHT: regs.frame_height   <= cfg_data[12:0];
                    REG_MAX_ITER:     regs.max_iterations <= cfg_data[10:0];
                    default:          ;
                endcase
            end
        end
    end

endmodule

@@ tb/sv/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import jem_pkg::*;

    localparam int LONG_HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES      = 3 * ITER_LIMIT_DEF + 16;
    localparam int RUN_LIMIT_NS     = 10_000_000;
    localparam int RANDOM_PHASES    = 9;
    localparam int PRESSURE_PHASE   = 1;
    localparam int DEEP_PHASE       = 3;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    in_item_t              in_item   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_item_t             out_item;
    int                    mismatches;
    int                    outstanding;

    bit   idle_en        = 1'b1;
    int   hold_asked     = 0;
    int   hold_served    = 0;
    int   pixels_sent    = 0;
    int   settings_used  = 0;
    cfg_t cur;

    // Well-known Julia constants, so that random frames show real structure.
    real julia_cr [6] = '{-0.8, -0.4, 0.285, -0.70176, -0.835, 0.0};
    real julia_ci [6] = '{0.156, 0.6, 0.01, -0.3842, -0.2321, 0.8};

    julia_escape_mask_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    jem_pixel_checker pixel_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_item     (in_item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_item    (out_item),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int q28(real v);
        return $rtoi(v * 268435456.0);
    endfunction

    function automatic cfg_t make_setting(int cr, int ci, int unsigned step, int cen_r,
                                          int cen_i, int w, int h, int iters);
        cfg_t c;
        c.c_real         = cr;
        c.c_imag         = ci;
        c.pixel_step     = step[30:0];
        c.center_real    = cen_r;
        c.center_imag    = cen_i;
        c.frame_width    = w[12:0];
        c.frame_height   = h[12:0];
        c.max_iterations = iters[10:0];
        return c;
    endfunction

    // Mostly inside the frame, now and then anywhere in the 12-bit range.
    function automatic logic [11:0] pick_coord(logic [12:0] size);
        if (size == 0 || $urandom_range(0, 9) == 0)
            return 12'($urandom_range(0, 4095));
        return 12'($urandom_range(0, ((size > 4096) ? 4096 : size) - 1));
    endfunction

    task automatic apply_setting(input cfg_t c);
        logic [CFG_DATA_W-1:0] vals [8];
        vals[REG_C_REAL]       = c.c_real;
        vals[REG_C_IMAG]       = c.c_imag;
        vals[REG_PIXEL_STEP]   = {1'b0, c.pixel_step};
        vals[REG_CENTER_REAL]  = c.center_real;
        vals[REG_CENTER_IMAG]  = c.center_imag;
        vals[REG_FRAME_WIDTH]  = CFG_DATA_W'(c.frame_width);
        vals[REG_FRAME_HEIGHT] = CFG_DATA_W'(c.frame_height);
        vals[REG_MAX_ITER]     = CFG_DATA_W'(c.max_iterations);
        for (int i = 0; i < 8; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        cur = c;
        settings_used++;
    endtask

    task automatic send_pixel(input logic [11:0] col, input logic [11:0] row);
        in_item  <= in_item_t'{column: col, row: row};
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pixels_sent++;
        if (idle_en && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // Drops valid and waits until every pixel sent so far has come back.
    task automatic wait_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    initial
    begin
        @(posedge clk);
        forever
        begin
            if (hold_served < hold_asked)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                hold_served++;
            end
            else if (idle_en && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values: frame center, a corner and a point outside the frame.
        send_pixel(12'd2000, 12'd1128);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        wait_results();

        apply_setting(make_setting(q28(-0.8), q28(0.156), q28(3.0) / 64, 0, 0, 64, 48, 64));
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd63, 12'd47);
        send_pixel(12'd32, 12'd24);
        send_pixel(12'd63, 12'd0);
        send_pixel(12'd0, 12'd47);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd0, 12'd4095);
        wait_results();

        // Register extremes with a single iteration.
        apply_setting(make_setting(int'(32'h8000_0000), int'(32'h7fff_ffff), 32'h7fff_ffff,
                                   int'(32'h7fff_ffff), int'(32'h8000_0000), 4096, 4096, 1));
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd2048, 12'd2048);
        send_pixel(12'd2048, 12'd0);
        wait_results();

        // Zero frame size and no iterations at all.
        apply_setting(make_setting(0, 0, 0, 0, 0, 0, 0, 0));
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd1, 12'd2);
        wait_results();

        // With c = -2 the orbit sits on |z| = 2 for good; the count is clamped.
        apply_setting(make_setting(q28(-2.0), 0, 0, 0, 0, 16, 16, 2047));
        send_pixel(12'd5, 12'd7);
        send_pixel(12'd15, 12'd15);
        wait_results();

        // Unit step: start points at exactly -4, 0, 1, 2 and -4i.
        apply_setting(make_setting(0, 0, q28(1.0), 0, 0, 8, 8, 16));
        send_pixel(12'd0, 12'd4);
        send_pixel(12'd4, 12'd4);
        send_pixel(12'd5, 12'd4);
        send_pixel(12'd6, 12'd4);
        send_pixel(12'd4, 12'd0);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            int          items, iters, w, h, pick;
            int unsigned step;
            int          cr, ci, cen_r, cen_i;
            if (p == DEEP_PHASE)
            begin
                items = 12;
                iters = ITER_LIMIT_DEF;
            end
            else if (p == PRESSURE_PHASE)
            begin
                items = 80;
                iters = $urandom_range(1, 6);
            end
            else if (p == RANDOM_PHASES - 1)
            begin
                items = 40;
                iters = $urandom_range(1, 48);
            end
            else
            begin
                items = 70;
                iters = $urandom_range(1, 48);
            end
            pick = $urandom_range(0, 9);
            w = (pick < 6) ? $urandom_range(1, 256) : (pick < 9) ? $urandom_range(257, 4096) : 4096;
            pick = $urandom_range(0, 9);
            h = (pick < 6) ? $urandom_range(1, 256) : (pick < 9) ? $urandom_range(257, 4096) : 4096;
            // Roughly four units of the plane across the frame.
            step = (32'd1 << 30) / w * $urandom_range(50, 150) / 100;
            if ($urandom_range(0, 9) == 0)
                step = $urandom() & 32'h7fff_ffff;
            if ($urandom_range(0, 19) < 17)
            begin
                cen_r = int'($urandom_range(0, 32'd1 << 29)) - (1 << 28);
                cen_i = int'($urandom_range(0, 32'd1 << 29)) - (1 << 28);
            end
            else
            begin
                cen_r = $urandom();
                cen_i = $urandom();
            end
            pick = $urandom_range(0, 19);
            if (pick < 12)
            begin
                cr = q28(julia_cr[pick % 6]);
                ci = q28(julia_ci[pick % 6]);
            end
            else if (pick < 17)
            begin
                cr = int'($urandom_range(0, 32'd1610612736)) - 805306368;
                ci = int'($urandom_range(0, 32'd1610612736)) - 805306368;
            end
            else
            begin
                cr = $urandom();
                ci = $urandom();
            end
            wait_results();
            if (p == RANDOM_PHASES - 1)
                idle_en = 1'b0;
            apply_setting(make_setting(cr, ci, step, cen_r, cen_i, w, h, iters));
            for (int i = 0; i < items; i++)
            begin
                if (p == PRESSURE_PHASE && i == 20)
                    hold_asked++;
                if (p == PRESSURE_PHASE && i == 60)
                    wait_results();
                send_pixel(pick_coord(cur.frame_width), pick_coord(cur.frame_height));
            end
        end

        wait_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Ran %0d pixels under %0d register settings: extremes, far and zero frames,",
                 pixels_sent, settings_used);
        $display("the iteration cap, random frames with stalls and one long output hold-off.");
        if (mismatches == 0 && outstanding == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
